// ----- sv/dest_pkg.sv -----
// ----------------------------------------------------------------------------
// dest_pkg
// Shared types, constants and helpers for the time-stamped double
// exponential smoothing filter (Q16.16 level and slope, Q0.16 gains).
// ----------------------------------------------------------------------------
package dest_pkg;

  localparam int TIME_BITS = 32;
  localparam int TIME_W    = 32;
  localparam int GAIN_W    = 16;
  localparam int SMP_W     = 16;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int D_W       = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int OP_W      = DATA_W + 1;
  localparam int PROD_W    = 2 * OP_W;
  localparam int ACC_W     = 52;
  localparam int DIV_W     = 49;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int CLAMP_W   = 41;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W:0]        ONE_Q16    = 17'd65536;
  localparam logic [CLAMP_W-1:0]     PROD_CLAMP = 41'h100_0000_0000;
  localparam logic signed [ACC_W-1:0] HALF_Q16  = 52'sd32768;
  localparam logic [GAIN_W-1:0]      GAIN_RESET = 16'd6554;

  localparam logic MODE_PRED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;

  typedef struct packed {
    logic                     mode;
    logic signed [SMP_W-1:0]  sample;
    logic [TIME_W-1:0]        time_stamp;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] level_out;
    logic signed [DATA_W-1:0] slope_out;
    logic [TIME_W-1:0]        time_out;
  } rsp_t;

  typedef enum logic [2:0] {
    MUL_EXT   = 3'd0,
    MUL_ASMP  = 3'd1,
    MUL_AEXT  = 3'd2,
    MUL_BDIFF = 3'd3,
    MUL_BSLP  = 3'd4
  } mul_op_t;

  typedef struct packed {
    logic    cap;
    logic    mul_en;
    mul_op_t mul_op;
    logic    ext_ld;
    logic    res_first;
    logic    t1_ld;
    logic    lvl_ld;
    logic    diff_ld;
    logic    div_start;
    logic    slp_ld;
    logic    out_ld;
    logic    commit;
  } cmd_t;

  typedef struct packed {
    logic pred;
    logic first;
    logic d_zero;
    logic div_busy;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:DATA_W-1]) || (~|v[ACC_W-1:DATA_W-1])) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- sv/double_exp_smoothing_trend_top.sv -----
// ----------------------------------------------------------------------------
// double_exp_smoothing_trend_top
// Time-stamped double exponential smoothing filter (level and per-tick slope).
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): one item per sample or query.
//     mode estimate updates the level and slope from sample at time_stamp;
//     mode predict extrapolates the level to time_stamp, state untouched.
//   rsp channel (rsp_valid/rsp_stall/rsp): exactly one item per request,
//     in order, held stable while rsp_stall is high.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 alpha,
//     index 1 beta, Q0.16. cfg_ready is always high; write only when idle.
// Path from accept to response valid: predict extrapolates only; the first
//   sample sets the level to the sample and the slope to zero; an estimate with
//   no elapsed ticks also blends the level; any other estimate also runs the
//   49-step serial divider and the shared multiplier passes for the slope. One
//   item is processed at a time; req_stall is low only while the sequencer is idle.
// A finished response waits in the output register; the sequencer takes the
// next request while it waits and stalls only at the end of that item if the
// register is still full.
// Reset (rst, synchronous): gains to 6554, level/slope/last time to zero,
// first-sample flag set, both channels empty.
// ----------------------------------------------------------------------------
module double_exp_smoothing_trend_top import dest_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dest_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dest_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp)
  );

endmodule

// ----- sv/dest_div.sv -----
// ----------------------------------------------------------------------------
// dest_div
// Serial restoring divider, one quotient bit per cycle. Divides the
// magnitude of a signed numerator by the elapsed ticks, rounding to nearest
// with halves away from zero, and returns the signed quotient.
// ----------------------------------------------------------------------------
module dest_div import dest_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic [D_W-1:0]          dvs,
  output logic                    busy,
  output logic signed [ACC_W-1:0] quo
);

  logic [DIV_W-1:0] dvd;
  logic [D_W-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [ACC_W-1:0] mag;
  logic [D_W:0]     r_sh;
  logic             q_bit;
  logic [ACC_W-1:0] q_ext;

  assign mag   = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign r_sh  = {rem, dvd[DIV_W-1]};
  assign q_bit = (r_sh >= {1'b0, dvs});
  assign q_ext = ACC_W'(dvd);
  assign quo   = neg ? -$signed(q_ext) : $signed(q_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= DIV_W'(mag) + DIV_W'(dvs >> 1);
      rem <= '0;
      neg <= num[ACC_W-1];
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], q_bit};
      rem <= q_bit ? D_W'(r_sh - {1'b0, dvs}) : r_sh[D_W-1:0];
    end
  end

endmodule

// ----- sv/dest_dp.sv -----
// ----------------------------------------------------------------------------
// dest_dp
// Datapath: gain registers, filter state, one shared registered multiplier,
// the serial divider and the rounding/saturation logic.
// ----------------------------------------------------------------------------
module dest_dp import dest_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  req_t                 req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output rsp_t                 rsp
);

  logic [GAIN_W-1:0]        alpha;
  logic [GAIN_W-1:0]        beta;
  logic                     first_flag;
  logic signed [DATA_W-1:0] level;
  logic signed [DATA_W-1:0] slope;
  logic [TIME_W-1:0]        last_time;

  req_t                     cur;
  logic [D_W-1:0]           d;
  logic [DATA_W-1:0]        smag;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] ext;
  logic signed [DATA_W-1:0] t1;
  logic signed [OP_W-1:0]   diff;
  logic signed [DATA_W-1:0] res_level;
  logic signed [DATA_W-1:0] res_slope;

  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  prod_lo;
  logic [2*DATA_W-1:0]      p_mag;
  logic [CLAMP_W-1:0]       pc;
  logic signed [ACC_W-1:0]  pc_s;
  logic signed [ACC_W-1:0]  lvl_s;
  logic signed [ACC_W-1:0]  ext_sum;
  logic signed [ACC_W-1:0]  mix_sum;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  quo;
  logic                     div_busy;

  dest_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod_lo),
    .dvs   (d),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign sts.pred     = (cur.mode == MODE_PRED);
  assign sts.first    = first_flag;
  assign sts.d_zero   = (d == '0);
  assign sts.div_busy = div_busy;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_EXT: begin
        mul_a = $signed({1'b0, smag});
        mul_b = $signed(OP_W'(d));
      end
      MUL_ASMP: begin
        mul_a = $signed({{(OP_W-GAIN_W){1'b0}}, alpha});
        mul_b = $signed({{(OP_W-SMP_W){cur.sample[SMP_W-1]}}, cur.sample});
      end
      MUL_AEXT: begin
        mul_a = $signed(OP_W'(ONE_Q16 - {1'b0, alpha}));
        mul_b = $signed({ext[DATA_W-1], ext});
      end
      MUL_BDIFF: begin
        mul_a = $signed({{(OP_W-GAIN_W){1'b0}}, beta});
        mul_b = diff;
      end
      MUL_BSLP: begin
        mul_a = $signed(OP_W'(ONE_Q16 - {1'b0, beta}));
        mul_b = $signed({slope[DATA_W-1], slope});
      end
      default: ;
    endcase
  end

  assign prod_lo = $signed(prod[ACC_W-1:0]);

  // slope * elapsed, clamped, then added to the level
  assign p_mag   = prod[2*DATA_W-1:0];
  assign pc      = (p_mag > (2*DATA_W)'(PROD_CLAMP)) ? PROD_CLAMP : p_mag[CLAMP_W-1:0];
  assign pc_s    = $signed(ACC_W'(pc));
  assign lvl_s   = $signed({{(ACC_W-DATA_W){level[DATA_W-1]}}, level});
  assign ext_sum = slope[DATA_W-1] ? (lvl_s - pc_s) : (lvl_s + pc_s);

  assign mix_sum = $signed({{(ACC_W-DATA_W-FRAC_W){t1[DATA_W-1]}}, t1, {FRAC_W{1'b0}}})
                   + prod_lo + HALF_Q16;
  assign acc_sum = quo + prod_lo + HALF_Q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= GAIN_RESET;
      beta  <= GAIN_RESET;
    end else if (cfg_we) begin
      priority if (cfg_index == CFG_ALPHA) begin
        alpha <= cfg_data;
      end else if (cfg_index == CFG_BETA) begin
        beta <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_flag <= 1'b1;
      level      <= '0;
      slope      <= '0;
      last_time  <= '0;
    end else if (cmd.commit) begin
      first_flag <= 1'b0;
      level      <= res_level;
      slope      <= res_slope;
      last_time  <= cur.time_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur  <= req;
      d    <= D_W'(req.time_stamp - last_time);
      smag <= slope[DATA_W-1] ? DATA_W'(-slope) : DATA_W'(slope);
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.t1_ld) begin
      t1 <= prod[DATA_W-1:0];
    end
    if (cmd.diff_ld) begin
      diff <= $signed({res_level[DATA_W-1], res_level}) - $signed({level[DATA_W-1], level});
    end
    if (cmd.ext_ld) begin
      ext       <= sat32(ext_sum);
      res_level <= sat32(ext_sum);
      res_slope <= slope;
    end else if (cmd.res_first) begin
      res_level <= {cur.sample, {FRAC_W{1'b0}}};
      res_slope <= '0;
    end else if (cmd.lvl_ld) begin
      res_level <= sat32(mix_sum >>> FRAC_W);
    end else if (cmd.slp_ld) begin
      res_slope <= sat32(acc_sum >>> FRAC_W);
    end
    if (cmd.out_ld) begin
      rsp.level_out <= res_level;
      rsp.slope_out <= res_slope;
      rsp.time_out  <= cur.time_stamp;
    end
  end

endmodule

// ----- sv/dest_ctrl.sv -----
// ----------------------------------------------------------------------------
// dest_ctrl
// Sequencer: steps the datapath through extrapolation, level blend, slope
// division and slope blend, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module dest_ctrl import dest_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'h0001,
    ST_EXT_MUL  = 14'h0002,
    ST_EXT_SUM  = 14'h0004,
    ST_FIRST    = 14'h0008,
    ST_A_SMP    = 14'h0010,
    ST_A_EXT    = 14'h0020,
    ST_MIX      = 14'h0040,
    ST_DIFF     = 14'h0080,
    ST_B_DIFF   = 14'h0100,
    ST_DIV_GO   = 14'h0200,
    ST_DIV_WAIT = 14'h0400,
    ST_B_SLP    = 14'h0800,
    ST_SLOPE    = 14'h1000,
    ST_FINISH   = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.cap    = 1'b1;
          state_next = ST_EXT_MUL;
        end
      end
      ST_EXT_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_EXT;
        state_next = ST_EXT_SUM;
      end
      ST_EXT_SUM: begin
        cmd.ext_ld = 1'b1;
        priority if (sts.pred) begin
          state_next = ST_FINISH;
        end else if (sts.first) begin
          state_next = ST_FIRST;
        end else begin
          state_next = ST_A_SMP;
        end
      end
      ST_FIRST: begin
        cmd.res_first = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_A_SMP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_ASMP;
        state_next = ST_A_EXT;
      end
      ST_A_EXT: begin
        cmd.t1_ld  = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_AEXT;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.lvl_ld = 1'b1;
        state_next = sts.d_zero ? ST_FINISH : ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_ld = 1'b1;
        state_next  = ST_B_DIFF;
      end
      ST_B_DIFF: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_BDIFF;
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          state_next = ST_B_SLP;
        end
      end
      ST_B_SLP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_BSLP;
        state_next = ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd.slp_ld = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          cmd.commit = !sts.pred;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_ld) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/dest_checker.sv -----
// ----------------------------------------------------------------------------
// dest_checker
// Port-level checks for the smoothing filter, bound to the top level.
// ----------------------------------------------------------------------------
module dest_checker import dest_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while an item is in work");

  a_no_instant_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !$rose(rsp_valid))
    else $error("response appeared one cycle after request");

  a_rsp_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !req_stall)
    else $error("new response while sequencer still busy");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind double_exp_smoothing_trend_top dest_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ----- tb/sv/double_exp_smoothing_trend_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_exp_smoothing_trend_top_tb
// Drives sample and predict items through the smoothing filter under several
// alpha/beta settings. A directed table comes first: predict before any
// sample, first sample, no elapsed ticks, wrapped and huge elapsed times,
// sample extremes. Trend-like random readings follow. Every result is
// checked against typed-in values or an in-bench fixed-point model, with
// random sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module double_exp_smoothing_trend_top_tb;
  import dest_pkg::*;

  localparam logic MODE_EST = ~MODE_PRED;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint EXT_CAP = 64'sh100_0000_0000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 250;
  localparam int NPROBE = 21;

  typedef struct packed {
    logic                     mode;
    logic signed [SMP_W-1:0]  sample;
    logic [TIME_W-1:0]        ts;
    logic                     known;
    logic signed [DATA_W-1:0] lvl;
    logic signed [DATA_W-1:0] slp;
  } probe_t;

  // known = 1: result typed in; otherwise taken from the model below
  localparam probe_t PROBES [NPROBE] = '{
    '{MODE_PRED, 16'sd0,      32'd0,          1'b1, 32'sd0,          32'sd0},
    '{MODE_PRED, 16'sh7fff,   32'hffff_ffff,  1'b1, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sh8000,   32'd100,        1'b1, 32'sh8000_0000,  32'sd0},
    '{MODE_EST,  16'sh7fff,   32'd100,        1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sh7fff,   32'd101,        1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sh7fff,   32'd102,        1'b0, 32'sd0,          32'sd0},
    '{MODE_PRED, 16'sd0,      32'hffff_ffff,  1'b0, 32'sd0,          32'sd0},
    '{MODE_PRED, 16'sd0,      32'd102,        1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sd0,      32'hffff_ffff,  1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'shffff,   32'd3,          1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sh8000,   32'd4,          1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sh7fff,   32'd5,          1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sd12345,  32'd5,          1'b0, 32'sd0,          32'sd0},
    '{MODE_PRED, 16'sd0,      32'd6,          1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sh8000,   32'd6,          1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sh7fff,   32'd7,          1'b0, 32'sd0,          32'sd0},
    '{MODE_PRED, 16'shffff,   32'd0,          1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sd1,      32'h8000_0000,  1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'shfffe,   32'h8000_0001,  1'b0, 32'sd0,          32'sd0},
    '{MODE_PRED, 16'sd0,      32'h7fff_ffff,  1'b0, 32'sd0,          32'sd0},
    '{MODE_EST,  16'sd0,      32'd0,          1'b0, 32'sd0,          32'sd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ALPHA;
  logic [GAIN_W-1:0] cfg_data = '0;

  double_exp_smoothing_trend_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // filter model state
  longint gain_a = 6554;
  longint gain_b = 6554;
  bit no_sample_yet = 1'b1;
  int filt_level = 0;
  int filt_slope = 0;
  logic [TIME_W-1:0] filt_time = '0;

  rsp_t filter_out_q[$];
  int n_est = 0, n_pred = 0, n_out = 0, n_bad = 0, n_settings = 1;
  int burst_left = 0;
  bit offering = 1'b0;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  // nearest, ties toward +inf
  function automatic longint rnd16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  // nearest, ties away from zero
  function automatic longint div_near(longint num, longint d);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + d / 2) / d;
    return (num < 0) ? -q : q;
  endfunction

  function automatic int project(int lv, int sl, longint d);
    longint mag, p;
    if (sl == 0 || d == 0) return lv;
    mag = (sl < 0) ? -longint'(sl) : longint'(sl);
    p = mag * d;
    if (p > EXT_CAP) p = EXT_CAP;
    if (sl < 0) p = -p;
    return clip32(longint'(lv) + p);
  endfunction

  function automatic rsp_t filter_step(req_t it);
    rsp_t o;
    logic [TIME_W-1:0] dd;
    longint smp, d, ext, mix, diff, q, acc;
    smp = longint'(it.sample);
    dd = it.time_stamp - filt_time;
    d = longint'({32'd0, dd});
    o.time_out = it.time_stamp;
    if (it.mode == MODE_PRED) begin
      o.level_out = project(filt_level, filt_slope, d);
      o.slope_out = filt_slope;
    end else if (no_sample_yet) begin
      o.level_out = clip32(smp * 65536);
      o.slope_out = '0;
      no_sample_yet = 1'b0;
    end else begin
      ext = longint'(project(filt_level, filt_slope, d));
      mix = gain_a * (smp * 65536) + (65536 - gain_a) * ext;
      o.level_out = clip32(rnd16(mix));
      if (d == 0) begin
        o.slope_out = filt_slope;
      end else begin
        diff = longint'(o.level_out) - longint'(filt_level);
        q = div_near(gain_b * diff, d);
        acc = q + (65536 - gain_b) * longint'(filt_slope);
        o.slope_out = clip32(rnd16(acc));
      end
    end
    if (it.mode != MODE_PRED) begin
      filt_level = o.level_out;
      filt_slope = o.slope_out;
      filt_time = it.time_stamp;
    end
    return o;
  endfunction

  task automatic offer(input req_t it, input bit known, input rsp_t fixed_rsp);
    rsp_t p;
    int gap;
    req <= it;
    req_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (req_stall);
    p = filter_step(it);
    filter_out_q.push_back(known ? fixed_rsp : p);
    if (it.mode == MODE_PRED) n_pred++;
    else n_est++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        req_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    if (offering) begin
      req_valid <= 1'b0;
      offering = 1'b0;
    end
    while (filter_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ALPHA) gain_a = longint'({48'd0, val});
    else if (idx == CFG_BETA) gain_b = longint'({48'd0, val});
    @(posedge clk);
  endtask

  // receiver: stall segments of varying density, one long hold-off
  int hold_left = 0, seg_left = 0, stall_pct = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= (hold_left != 0);
    end else if (!hold_done && n_out >= 300) begin
      hold_done = 1'b1;
      hold_left = 600;
      rsp_stall <= 1'b1;
    end else begin
      if (seg_left <= 0) begin
        seg_left = $urandom_range(1, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 75;
          default: stall_pct = 95;
        endcase
      end
      seg_left--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_out++;
      if (filter_out_q.size() == 0) begin
        $error("result with nothing outstanding: level %0d slope %0d time %0d",
               rsp.level_out, rsp.slope_out, rsp.time_out);
        n_bad++;
      end else begin
        want = filter_out_q.pop_front();
        if (rsp.level_out !== want.level_out) begin
          $error("level_out expected %0d actual %0d", want.level_out, rsp.level_out);
          n_bad++;
        end
        if (rsp.slope_out !== want.slope_out) begin
          $error("slope_out expected %0d actual %0d", want.slope_out, rsp.slope_out);
          n_bad++;
        end
        if (rsp.time_out !== want.time_out) begin
          $error("time_out expected %0d actual %0d", want.time_out, rsp.time_out);
          n_bad++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    req_t it;
    rsp_t fixed_rsp;
    int ph, k, i, r, trend;
    logic [TIME_W-1:0] tcur;
    logic [GAIN_W-1:0] ga, gb;
    trend = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NPROBE; i++) begin
      it.mode = PROBES[i].mode;
      it.sample = PROBES[i].sample;
      it.time_stamp = PROBES[i].ts;
      fixed_rsp.level_out = PROBES[i].lvl;
      fixed_rsp.slope_out = PROBES[i].slp;
      fixed_rsp.time_out = PROBES[i].ts;
      offer(it, PROBES[i].known, fixed_rsp);
    end
    tcur = filt_time;

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: begin ga = 16'd1; gb = 16'd1; end
          2: begin ga = 16'hffff; gb = 16'hffff; end
          3: begin ga = 16'd0; gb = 16'd0; end
          4: begin ga = 16'hffff; gb = 16'd1; end
          default: begin
            ga = GAIN_W'($urandom_range(1, 65535));
            gb = GAIN_W'($urandom_range(1, 65535));
          end
        endcase
        write_gain(CFG_ALPHA, ga);
        write_gain(CFG_BETA, gb);
        if (ph == 3) write_gain(CFG_SPARE, GAIN_W'($urandom));
        n_settings++;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        it.mode = ($urandom_range(0, 9) < 7) ? MODE_EST : MODE_PRED;
        r = $urandom_range(0, 99);
        if (r < 10) begin
          case ($urandom_range(0, 3))
            0: it.sample = 16'sh7fff;
            1: it.sample = 16'sh8000;
            2: it.sample = 16'sd0;
            default: it.sample = 16'shffff;
          endcase
        end else if (r < 60) begin
          trend = trend + int'($urandom_range(0, 1000)) - 500;
          if (trend > 32767) trend = 32767;
          if (trend < -32768) trend = -32768;
          it.sample = trend[SMP_W-1:0];
        end else begin
          it.sample = SMP_W'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 8) it.time_stamp = tcur;
        else if (r < 65) it.time_stamp = tcur + $urandom_range(1, 16);
        else if (r < 85) it.time_stamp = tcur + $urandom_range(17, 100000);
        else if (r < 93) it.time_stamp = $urandom;
        else it.time_stamp = tcur - $urandom_range(1, 1000);
        if (it.mode == MODE_EST) tcur = it.time_stamp;
        offer(it, 1'b0, '0);
      end
    end

    settle();
    repeat (80) @(posedge clk);
    $display("covered %0d estimate and %0d predict items under %0d gain settings,",
             n_est, n_pred, n_settings);
    $display("%0d results compared, including a long output hold-off", n_out);
    if (n_bad == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
